// ===== sv/rycc_pkg.sv =====
// ----------------------------------------------------------------------------
// rycc_pkg
// Types and constants shared by the YCoCg-R 4:2:0 block converter.
// ----------------------------------------------------------------------------
package rycc_pkg;

   localparam int PixW  = 8;
   localparam int DiffW = PixW + 1;   // signed R-B, G-t
   localparam int PairW = DiffW + 1;  // sum of two differences
   localparam int SumW  = PairW + 1;  // sum of four differences
   localparam int Lanes = 4;          // pixels in a 2x2 block
   localparam logic [SumW-1:0] ChromaBias = SumW'(1024);

   typedef logic [PixW-1:0]         pix_type;
   typedef logic signed [DiffW-1:0] diff_type;
   typedef logic signed [PairW-1:0] pair_type;
   typedef logic signed [SumW-1:0]  sum_type;

   typedef struct packed {
      pix_type blue_tl;
      pix_type green_tl;
      pix_type red_tl;
      pix_type blue_tr;
      pix_type green_tr;
      pix_type red_tr;
      pix_type blue_bl;
      pix_type green_bl;
      pix_type red_bl;
      pix_type blue_br;
      pix_type green_br;
      pix_type red_br;
   } req_beat_type;

   typedef struct packed {
      pix_type luma_tl;
      pix_type luma_tr;
      pix_type luma_bl;
      pix_type luma_br;
      pix_type chroma_orange;
      pix_type chroma_green;
   } rsp_beat_type;

endpackage

// ===== sv/rycc_if.sv =====
// ----------------------------------------------------------------------------
// rycc_req_if / rycc_rsp_if
// Valid/ready channels carrying a pixel block beat and a result beat.
// ----------------------------------------------------------------------------
interface rycc_req_if import rycc_pkg::*; ();
   logic         valid;
   logic         ready;
   req_beat_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rycc_rsp_if import rycc_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_beat_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rgb_to_ycocg_r_420_block_core.sv =====
// ----------------------------------------------------------------------------
// rgb_to_ycocg_r_420_block_core
// 2x2 block RGB to YCoCg-R converter with 4:2:0 chroma averaging.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one 2x2 block of 8-bit B,G,R pixels per beat; rsp returns
//   four luma bytes and one Co/Cg pair per block, one result per request.
//   Four register stages: R-B; t and Cg; Y and pairwise chroma sums;
//   final chroma sum, bias and output register. An accepted req beat
//   passes through these stages in order before it shows on rsp.valid.
//   Throughput is one block per cycle while rsp.ready stays high, with the
//   pipeline advancing as it drains; each stage holds its own valid bit.
//   When rsp.ready is low, results collect in the stages; req.ready stays
//   high until all four stages are full, and nothing is dropped or
//   duplicated. Bubbles are squeezed out by the per-stage ready chain.
//   Reset (synchronous, active high) empties the pipeline.
// ----------------------------------------------------------------------------
module rgb_to_ycocg_r_420_block_core
   import rycc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rycc_req_if.sink    req,
   rycc_rsp_if.source  rsp
);

   // stage valids and ready chain
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4 = !v4_ff || rsp.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req.ready = rdy1;

   // input lanes
   pix_type b_lane [Lanes];
   pix_type g_lane [Lanes];
   pix_type r_lane [Lanes];

   always_comb begin
      b_lane[0] = req.data.blue_tl;  g_lane[0] = req.data.green_tl;
      r_lane[0] = req.data.red_tl;
      b_lane[1] = req.data.blue_tr;  g_lane[1] = req.data.green_tr;
      r_lane[1] = req.data.red_tr;
      b_lane[2] = req.data.blue_bl;  g_lane[2] = req.data.green_bl;
      r_lane[2] = req.data.red_bl;
      b_lane[3] = req.data.blue_br;  g_lane[3] = req.data.green_br;
      r_lane[3] = req.data.red_br;
   end

   // stage 1: Co
   diff_type co1_ff [Lanes];
   diff_type co1_in [Lanes];
   pix_type  b1_ff  [Lanes];
   pix_type  g1_ff  [Lanes];

   // stage 2: t, Cg
   diff_type co2_ff [Lanes];
   diff_type cg2_ff [Lanes];
   diff_type cg2_in [Lanes];
   pix_type  t2_ff  [Lanes];
   pix_type  t2_in  [Lanes];

   // stage 3: Y, pair sums
   pix_type  y3_ff  [Lanes];
   pix_type  y3_in  [Lanes];
   pair_type co_pair3_ff [2];
   pair_type cg_pair3_ff [2];
   pair_type co_pair3_in [2];
   pair_type cg_pair3_in [2];

   // stage 4: output
   rsp_beat_type out4_ff, out4_in;
   sum_type      co_sum4, cg_sum4;
   logic [SumW-1:0] co_bias4, cg_bias4;

   always_comb begin
      diff_type t_w;
      diff_type y_w;
      t_w = '0;
      y_w = '0;
      for (int k = 0; k < Lanes; k++) begin
         co1_in[k] = $signed({1'b0, r_lane[k]}) - $signed({1'b0, b_lane[k]});
         t_w       = $signed({1'b0, b1_ff[k]}) + (co1_ff[k] >>> 1);
         t2_in[k]  = t_w[PixW-1:0];   // t lies between B and R
         cg2_in[k] = $signed({1'b0, g1_ff[k]}) - t_w;
         y_w       = $signed({1'b0, t2_ff[k]}) + (cg2_ff[k] >>> 1);
         y3_in[k]  = y_w[PixW-1:0];
      end
      for (int p = 0; p < 2; p++) begin
         co_pair3_in[p] = PairW'(co2_ff[2*p]) + PairW'(co2_ff[2*p+1]);
         cg_pair3_in[p] = PairW'(cg2_ff[2*p]) + PairW'(cg2_ff[2*p+1]);
      end
   end

   always_comb begin
      co_sum4  = SumW'(co_pair3_ff[0]) + SumW'(co_pair3_ff[1]);
      cg_sum4  = SumW'(cg_pair3_ff[0]) + SumW'(cg_pair3_ff[1]);
      // sums stay within -1020..1020, so the biased value is positive
      co_bias4 = co_sum4 + ChromaBias;
      cg_bias4 = cg_sum4 + ChromaBias;
      out4_in.luma_tl       = y3_ff[0];
      out4_in.luma_tr       = y3_ff[1];
      out4_in.luma_bl       = y3_ff[2];
      out4_in.luma_br       = y3_ff[3];
      out4_in.chroma_orange = co_bias4[SumW-1:3];
      out4_in.chroma_green  = cg_bias4[SumW-1:3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         co1_ff <= co1_in;
         b1_ff  <= b_lane;
         g1_ff  <= g_lane;
      end
      if (rdy2) begin
         co2_ff <= co1_ff;
         cg2_ff <= cg2_in;
         t2_ff  <= t2_in;
      end
      if (rdy3) begin
         y3_ff       <= y3_in;
         co_pair3_ff <= co_pair3_in;
         cg_pair3_ff <= cg_pair3_in;
      end
      if (rdy4) begin
         out4_ff <= out4_in;
      end
   end

   assign rsp.valid = v4_ff;
   assign rsp.data  = out4_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid right after reset");

   a_backpressure_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready == (v1_ff && v2_ff && v3_ff && v4_ff && !rsp.ready))
      else $error("req.ready does not match pipeline occupancy");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) ##1 rsp.ready ##1 rsp.ready ##1 rsp.ready
      |=> rsp.valid)
      else $error("accepted block did not reach the output in four cycles");

endmodule
